@@ rtl/mgrad_pkg.sv @@
// Shared types and constants for the cross-shaped morphological gradient block.
package mgrad_pkg;

  localparam int WidthBits = 11;
  localparam logic [WidthBits-1:0] WidthReset = 11'd1024;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [7:0] gradient;
    logic       row_end;
    logic       image_end;
  } out_word_t;

endpackage

@@ rtl/mgrad_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module mgrad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/morph_gradient_cross3x3_u8.sv @@
// Top level of the streaming 3x3 cross morphological gradient for 8-bit grey pixels.
//
//   Channel   Signals                          Direction  Word
//   input     in_valid / in_ready / in_data    in         action, pixel
//   output    out_valid / out_ready / out_data out        gradient, row_end, image_end
//   config    cfg_wr_en / cfg_wr_data          in         image_width
//
// One word is accepted per clock; its result is registered, valid the next cycle.
// The line stores are read ahead at the column the next word will use,
// so the registered read port of the memories is hidden behind the column counter.
// Reset is synchronous; the stores keep their contents and no clearing pass runs.
// in_ready drops for one cycle after reset and after each configuration write
// while the stores are re-read, and whenever the output register is full and
// out_ready is low.
module morph_gradient_cross3x3_u8
  import mgrad_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [WidthBits-1:0] cfg_wr_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  // Configuration and control state.
  logic [WidthBits-1:0] image_width;
  logic [AW-1:0]        col;
  logic [1:0]           rows_seen;
  logic [7:0]           win_center;
  logic                 rd_ok;

  // Forwarding flags for a read issued on the same edge as a write to that entry.
  logic       fwd_c;
  logic       fwd_e;
  logic       fwd_n;
  logic [7:0] fwd_pix;
  logic [7:0] fwd_old;

  // Memory read data and write controls.
  logic [7:0]    ram_c_q;
  logic [7:0]    ram_e_q;
  logic [7:0]    ram_n_q;
  logic          new_we;
  logic          old_we;
  logic [AW-1:0] rd_c;
  logic [AW-1:0] rd_e;

  // Per-word datapath.
  logic          accept;
  logic [AW-1:0] last;
  logic [AW-1:0] cur;
  logic [7:0]    center;
  logic [7:0]    east;
  logic [7:0]    north;
  logic [7:0]    west;
  logic [7:0]    south;
  logic [7:0]    hi;
  logic [7:0]    lo;
  logic          is_last;
  logic          has_result;
  logic          is_flush;
  logic [AW-1:0] col_next;
  logic [1:0]    rows_seen_next;
  logic [7:0]    win_center_next;
  out_word_t     result;

  // Effective last column: a width of zero acts as one, an oversized width
  // is clipped to the store depth.
  always_comb begin
    if (image_width == '0) begin
      last = '0;
    end else if (int'(image_width) > MAX_WIDTH) begin
      last = AW'(MAX_WIDTH - 1);
    end else begin
      last = AW'(image_width - 1'b1);
    end
  end

  assign cur      = (col > last) ? last : col;
  assign is_last  = (cur == last);
  assign is_flush = (in_data.action == ACT_FLUSH);

  // The output register frees itself in the same cycle it is drained.
  assign in_ready = rd_ok && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Neighborhood of the current column. The west pixel is the previous
  // result's center, except on the first column where the border repeats.
  assign center = fwd_c ? fwd_pix : ram_c_q;
  assign east   = is_last ? center : (fwd_e ? fwd_pix : ram_e_q);
  assign north  = (rows_seen >= 2'd2) ? (fwd_n ? fwd_old : ram_n_q) : center;
  assign west   = (cur == '0) ? center : win_center;
  assign south  = is_flush ? center : in_data.pixel;

  always_comb begin
    hi = center;
    lo = center;
    if (north > hi) hi = north;
    if (west  > hi) hi = west;
    if (east  > hi) hi = east;
    if (south > hi) hi = south;
    if (north < lo) lo = north;
    if (west  < lo) lo = west;
    if (east  < lo) lo = east;
    if (south < lo) lo = south;
  end

  assign has_result       = (rows_seen != 2'd0);
  assign result.gradient  = hi - lo;
  assign result.row_end   = is_last;
  assign result.image_end = is_flush && is_last;

  // Line store writes: the arriving pixel replaces the newer row entry, and
  // the old newer-row value moves down into the older row.
  assign new_we = accept && !is_flush;
  assign old_we = accept && !is_flush && has_result;

  // Next column, row count and window after this word.
  always_comb begin
    col_next        = col;
    rows_seen_next  = rows_seen;
    win_center_next = win_center;
    if (accept) begin
      if (!is_flush) begin
        if (has_result) begin
          win_center_next = center;
        end
        if (is_last) begin
          col_next = '0;
          if (rows_seen != 2'd2) begin
            rows_seen_next = rows_seen + 2'd1;
          end
        end else begin
          col_next = cur + 1'b1;
        end
      end else if (has_result) begin
        if (is_last) begin
          col_next        = '0;
          rows_seen_next  = 2'd0;
          win_center_next = '0;
        end else begin
          col_next        = cur + 1'b1;
          win_center_next = center;
        end
      end
    end
  end

  // Read addresses for the next word, issued ahead of it.
  assign rd_c = (col_next > last) ? last : col_next;
  assign rd_e = (rd_c == last) ? rd_c : rd_c + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WidthReset;
      col         <= '0;
      rows_seen   <= 2'd0;
      win_center  <= '0;
      rd_ok       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        image_width <= cfg_wr_data;
      end
      col        <= col_next;
      rows_seen  <= rows_seen_next;
      win_center <= win_center_next;
      // A new width may move the clamped column, so the prefetch is redone.
      rd_ok      <= !cfg_wr_en;
      if (accept && (has_result)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register and forwarding records; these need no reset.
  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_data <= result;
    end
    fwd_c   <= new_we && (rd_c == cur);
    fwd_e   <= new_we && (rd_e == cur);
    fwd_n   <= old_we && (rd_c == cur);
    fwd_pix <= in_data.pixel;
    fwd_old <= center;
  end

  // The newer row is kept twice so that center and east are read in the same cycle.
  mgrad_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_newer_c (
    .clk  (clk),
    .we   (new_we),
    .waddr(cur),
    .wdata(in_data.pixel),
    .raddr(rd_c),
    .rdata(ram_c_q)
  );

  mgrad_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_newer_e (
    .clk  (clk),
    .we   (new_we),
    .waddr(cur),
    .wdata(in_data.pixel),
    .raddr(rd_e),
    .rdata(ram_e_q)
  );

  mgrad_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_older (
    .clk  (clk),
    .we   (old_we),
    .waddr(cur),
    .wdata(center),
    .raddr(rd_c),
    .rdata(ram_n_q)
  );

endmodule

@@ bench/morph_gradient_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts and compares the gradient words of the cross-shaped gradient block.
module morph_gradient_checker
  import mgrad_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_word_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [WidthBits-1:0] cfg_wr_data,
  output int                   mismatch_count,
  output int                   results_due,
  output int                   results_checked,
  output int                   next_column,
  output int                   complete_rows
);

  logic [7:0]           older_line [MAX_WIDTH];
  logic [7:0]           newer_line [MAX_WIDTH];
  logic [7:0]           last_center;
  logic [WidthBits-1:0] width_reg;
  out_word_t            gradients_due [$];

  initial begin
    mismatch_count  = 0;
    results_checked = 0;
  end

  function automatic int last_column();
    if (width_reg == 0) return 0;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH - 1;
    return int'(width_reg) - 1;
  endfunction

  // Spread of north, west, center, east and south at column c of the newer row.
  function automatic logic [7:0] cross_spread(int c, int last, bit has_south,
                                              logic [7:0] south);
    logic [7:0] v [5];
    logic [7:0] hi;
    logic [7:0] lo;
    v[2] = newer_line[c];
    v[0] = (complete_rows >= 2) ? older_line[c] : v[2];
    v[1] = (c == 0) ? v[2] : last_center;
    v[3] = (c >= last) ? v[2] : newer_line[c + 1];
    v[4] = has_south ? south : v[2];
    hi = v[0];
    lo = v[0];
    for (int k = 1; k < 5; k++) begin
      if (v[k] > hi) hi = v[k];
      if (v[k] < lo) lo = v[k];
    end
    last_center = v[2];
    return hi - lo;
  endfunction

  task automatic advance_image(in_word_t w);
    int        last;
    int        c;
    out_word_t res;
    last = last_column();
    c = (next_column > last) ? last : next_column;
    if (w.action == ACT_PIXEL) begin
      if (complete_rows >= 1) begin
        res.gradient  = cross_spread(c, last, 1'b1, w.pixel);
        res.row_end   = (c == last);
        res.image_end = 1'b0;
        gradients_due.push_back(res);
        older_line[c] = newer_line[c];
      end
      newer_line[c] = w.pixel;
      if (c == last) begin
        next_column = 0;
        if (complete_rows < 2) complete_rows++;
      end else begin
        next_column = c + 1;
      end
    end else if (complete_rows != 0) begin
      res.gradient  = cross_spread(c, last, 1'b0, 8'h00);
      res.row_end   = (c == last);
      res.image_end = (c == last);
      gradients_due.push_back(res);
      if (c == last) begin
        next_column   = 0;
        complete_rows = 0;
        last_center   = 8'h00;
      end else begin
        next_column = c + 1;
      end
    end
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t ns: %s is %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (gradients_due.size() == 0) begin
      report_mismatch("unexpected word, gradient", got.gradient, -1);
      return;
    end
    want = gradients_due.pop_front();
    results_checked++;
    if (got.gradient !== want.gradient)
      report_mismatch("gradient", got.gradient, want.gradient);
    if (got.row_end !== want.row_end)
      report_mismatch("row_end", got.row_end, want.row_end);
    if (got.image_end !== want.image_end)
      report_mismatch("image_end", got.image_end, want.image_end);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      next_column   = 0;
      complete_rows = 0;
      last_center   = 8'h00;
      width_reg     = WidthReset;
      gradients_due.delete();
    end else begin
      // A word taken on the edge of a register write still sees the old width.
      if (in_valid && in_ready) advance_image(in_data);
      if (cfg_wr_en) width_reg = cfg_wr_data;
      if (out_valid && out_ready) check_result(out_data);
    end
    results_due = gradients_due.size();
  end

endmodule

@@ bench/tb_morph_gradient_cross3x3_u8.sv @@
`timescale 1ns / 100ps
// Stimulus, stall patterns and verdict for the cross-shaped morphological gradient block.
module tb_morph_gradient_cross3x3_u8;
  import mgrad_pkg::*;

  localparam int MaxWidth = 1024;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [WidthBits-1:0] cfg_wr_data = '0;

  int mismatch_count;
  int results_due;
  int results_checked;
  int next_column;
  int complete_rows;

  // Stimulus bookkeeping: the width in force, the sender's burst state and
  // a count of the words that reach the block's image logic.
  int active_width = MaxWidth;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  bit long_hold_req = 1'b0;
  int words_used = 0;
  int images_run = 0;

  always #5 clk = ~clk;

  morph_gradient_cross3x3_u8 #(
    .MAX_WIDTH(MaxWidth)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // The checker watches both channels and the register port, keeps its own
  // model of the line stores and compares every result word.
  morph_gradient_checker #(
    .MAX_WIDTH(MaxWidth)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due),
    .results_checked(results_checked),
    .next_column    (next_column),
    .complete_rows  (complete_rows)
  );

  // Grey levels lean toward black and white so the extremes show up often,
  // while the rest are uniform so every pixel bit toggles.
  function automatic logic [7:0] grey_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Every stimulus task starts and ends on a falling edge, so the checker's
  // view of column and row count is settled when the next word is chosen.
  // A word is offered with valid held high until the handshake at a rising edge.
  task automatic send_word(action_t act, logic [7:0] px);
    if (gaps_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    // A flush with no complete row is dropped by the block, so it is not counted.
    if (act == ACT_PIXEL || complete_rows != 0) words_used++;
    in_data.action = act;
    in_data.pixel  = px;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has come out.
  task automatic drain();
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // The register is only written with the block idle, once every predicted result is out.
  task automatic set_width(logic [WidthBits-1:0] raw);
    drain();
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = raw;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (raw == 0) active_width = 1;
    else if (raw > MaxWidth) active_width = MaxWidth;
    else active_width = raw;
  endtask

  // Narrowing mid-image is safe: every column still read was written in this
  // image. Widening is kept to image starts so no line store entry is read
  // before it has been written.
  task automatic narrow_width();
    int w;
    w = $urandom_range(1, active_width);
    if (w == 1 && $urandom_range(0, 1) == 1) set_width('0);
    else set_width(WidthBits'(w));
  endtask

  // One image: rows of random pixels, then flushes until the last row is out.
  // A stray flush now and then cuts the image short mid-row; once flushing
  // with two complete rows, a pixel is sometimes slipped in. Pixels inside a
  // flush are only sent with two complete rows, since with one row the older
  // store would be read at columns this image never filled.
  task automatic run_image(int rows_wanted);
    bit      flushing;
    bit      closes;
    int      rows_fed;
    int      c;
    action_t act;
    flushing = 1'b0;
    rows_fed = 0;
    forever begin
      c = (next_column > active_width - 1) ? active_width - 1 : next_column;
      if (flushing || rows_fed >= rows_wanted) act = ACT_FLUSH;
      else act = ($urandom_range(0, 39) == 0) ? ACT_FLUSH : ACT_PIXEL;
      if (act == ACT_FLUSH && flushing && complete_rows == 2 && $urandom_range(0, 7) == 0)
        act = ACT_PIXEL;
      if (act == ACT_FLUSH && complete_rows != 0) flushing = 1'b1;
      closes = (act == ACT_FLUSH) && (complete_rows != 0) && (c == active_width - 1);
      if (act == ACT_PIXEL && !flushing && c == active_width - 1) rows_fed++;
      send_word(act, grey_level());
      if (closes) break;
      if ($urandom_range(0, 59) == 0) narrow_width();
      else if ($urandom_range(0, 79) == 0) drain();
    end
    images_run++;
  endtask

  // Receiver: after reset it runs stall patterns of random length. Once the
  // random stimulus starts it holds ready low for a long counted stretch, so
  // the output register fills and the block pushes back on its input.
  initial begin
    int mode;
    int span;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (64) @(negedge clk);
      end
      mode = $urandom_range(0, 15);
      span = (mode == 15) ? $urandom_range(30, 80) : $urandom_range(8, 48);
      repeat (span) begin
        if (mode < 6) out_ready = 1'b1;
        else if (mode < 11) out_ready = 1'($urandom_range(0, 1));
        else if (mode < 15) out_ready = ($urandom_range(0, 3) == 0);
        else out_ready = 1'b0;
        @(negedge clk);
      end
    end
  end

  initial begin
    int rows;
    int pick;
    in_data.action = ACT_PIXEL;
    in_data.pixel  = 8'h00;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part. A written width of zero behaves as a single column: a
    // flush before any complete row is ignored, the first pixel gives nothing,
    // and each later pixel closes its own row.
    gaps_on = 1'b1;
    set_width('0);
    send_word(ACT_FLUSH, 8'h5a);
    send_word(ACT_PIXEL, 8'hff);
    send_word(ACT_PIXEL, 8'h00);
    send_word(ACT_PIXEL, 8'h80);
    send_word(ACT_FLUSH, 8'h00);

    // A single-row image of width three: north and south both fall back to center.
    set_width(WidthBits'(3));
    send_word(ACT_PIXEL, 8'h00);
    send_word(ACT_PIXEL, 8'hff);
    send_word(ACT_PIXEL, 8'h11);
    repeat (3) send_word(ACT_FLUSH, 8'hff);

    // Two full rows, a partial third row cut by a flush, a pixel slipped into
    // the flush that closes the row, then a full flush of the last row.
    send_word(ACT_PIXEL, 8'hff);
    send_word(ACT_PIXEL, 8'h00);
    send_word(ACT_PIXEL, 8'hff);
    send_word(ACT_PIXEL, 8'h00);
    send_word(ACT_PIXEL, 8'hff);
    send_word(ACT_PIXEL, 8'h00);
    send_word(ACT_PIXEL, 8'h7f);
    send_word(ACT_FLUSH, 8'h00);
    send_word(ACT_PIXEL, 8'h80);
    repeat (3) send_word(ACT_FLUSH, 8'h00);

    // Random images, mostly narrow. The first runs without gaps while the
    // receiver holds off, so the block backs up into the sender.
    drain();
    long_hold_req = 1'b1;
    wait (!long_hold_req);
    gaps_on = 1'b0;
    set_width(WidthBits'(8));
    run_image(3);
    while (words_used < 470) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) set_width('0);
      else if (pick == 1) set_width(WidthBits'(1));
      else if (pick < 8) set_width(WidthBits'($urandom_range(2, 8)));
      else set_width(WidthBits'($urandom_range(9, 32)));
      rows = $urandom_range(1, 4);
      run_image(rows);
      gaps_on = ($urandom_range(0, 3) != 0);
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Covered %0d image words over %0d images; %0d gradient words compared.",
             words_used, images_run, results_checked);
    $display("Widths ran from one column up to 32, with narrowing mid-image.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Far beyond the slowest correct run, including every long receiver stall.
  initial begin
    #2000000;
    $display("Timed out with %0d results still due.", results_due);
    $display("Mismatches found");
    $finish;
  end

endmodule
